[hdl/tcb_pkg.sv]
// tcb_pkg: shared types, constants and colour decode for the text cell buffer
// depends on nothing; used by text_cell_buffer_engine_core
package tcb_pkg;

    localparam int MAX_LINE_CELLS_DEF = 128;
    localparam int MAX_LINES_DEF      = 32;
    localparam int CPL_RESET          = 80;
    localparam int LC_RESET           = 25;

    localparam int CFG_DATA_W = 8;
    localparam int LC_CFG_W   = 6;

    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [3:0] FG_RESET   = 4'd7;
    localparam logic [3:0] BG_RESET   = 4'd0;

    localparam logic [6:0] SGR_FG_LO    = 7'd30;
    localparam logic [6:0] SGR_FG_HI    = 7'd37;
    localparam logic [6:0] SGR_FG_BR_LO = 7'd90;
    localparam logic [6:0] SGR_FG_BR_HI = 7'd97;
    localparam logic [6:0] SGR_BG_LO    = 7'd40;
    localparam logic [6:0] SGR_BG_HI    = 7'd47;
    localparam logic [6:0] SGR_BG_BR_LO = 7'd100;
    localparam logic [6:0] SGR_BG_BR_HI = 7'd107;

    // ansi color index to vga color index
    localparam logic [2:0] VGA_ORDER [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    typedef enum logic [0:0] {
        CFG_CELLS_PER_LINE = 1'b0,
        CFG_LINE_COUNT     = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        MODE_PUT          = 4'd0,
        MODE_SCROLL_UP    = 4'd1,
        MODE_SCROLL_DOWN  = 4'd2,
        MODE_CLEAR_CELL   = 4'd3,
        MODE_CLEAR_RANGE  = 4'd4,
        MODE_CLEAR_LINE   = 4'd5,
        MODE_CLEAR_SCREEN = 4'd6,
        MODE_SET_COLOUR   = 4'd7,
        MODE_READ         = 4'd8
    } mode_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_COPY,
        ST_FILL
    } state_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [4:0] line;
        logic [7:0] range_end;
        logic [6:0] sgr_code;
    } cmd_t;

    typedef struct packed {
        logic [15:0] cell_data;
        logic        rejected;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic       bg;
        logic [3:0] color;
    } sgr_t;

    function automatic sgr_t sgr_decode(input logic [6:0] v);
        sgr_t r;
        r = '{hit: 1'b0, bg: 1'b0, color: 4'd0};
        if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
            r.hit   = 1'b1;
            r.color = {1'b0, VGA_ORDER[3'(v - SGR_FG_LO)]};
        end else if (v >= SGR_FG_BR_LO && v <= SGR_FG_BR_HI) begin
            r.hit   = 1'b1;
            r.color = {1'b1, VGA_ORDER[3'(v - SGR_FG_BR_LO)]};
        end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
            r.hit   = 1'b1;
            r.bg    = 1'b1;
            r.color = {1'b0, VGA_ORDER[3'(v - SGR_BG_LO)]};
        end else if (v >= SGR_BG_BR_LO && v <= SGR_BG_BR_HI) begin
            r.hit   = 1'b1;
            r.bg    = 1'b1;
            r.color = {1'b1, VGA_ORDER[3'(v - SGR_BG_BR_LO)]};
        end
        return r;
    endfunction

endpackage

[hdl/text_cell_buffer_engine_core.sv]
// text_cell_buffer_engine_core: text-mode cell buffer with put, scroll, clear,
// set colour and read commands over one synchronous cell memory
// depends on tcb_pkg
//
// usage:
//   command channel: a transaction is taken at a rising edge with start high
//   and busy low; cmd carries mode and operands. every command returns
//   exactly one result on result, marked by done for one cycle; the receiver
//   cannot stall, so the result must be taken in that cycle.
//   config channel: cfg_ready is always high; cfg_index/cfg_data write
//   cells_per_line or line_count, clamped to 1..maximum. write only while idle.
// command flow:
//   put, clear cell, set colour, rejected commands: done follows ST_EXEC, and a new
//   transaction can be taken once busy is low again
//   read: ST_EXEC addresses the memory, ST_READ returns its registered read data
//   clear range/line/screen: ST_FILL writes the cleared cells
//   scroll: ST_COPY moves the other lines (skipped with one line), then ST_FILL blanks a line,
//   one memory copy per cycle through the single read port and single write port
// reset: all MAX_LINE_CELLS * MAX_LINES cells (4096 by default) are zeroed in ST_CLEAR
//   with busy high; config writes are still taken.
module text_cell_buffer_engine_core
    import tcb_pkg::*;
#(
    parameter int MAX_LINE_CELLS = MAX_LINE_CELLS_DEF,
    parameter int MAX_LINES      = MAX_LINES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cmd_t                  cmd,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH    = MAX_LINE_CELLS * MAX_LINES;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CPL_W    = $clog2(MAX_LINE_CELLS + 1);
    localparam int LC_W     = $clog2(MAX_LINES + 1);
    localparam int EW       = (CPL_W > 8) ? CPL_W : 8;
    localparam int PW       = 5 + CPL_W;
    localparam int SPW      = CPL_W + LC_W;
    localparam int CPL_INIT = (CPL_RESET > MAX_LINE_CELLS) ? MAX_LINE_CELLS : CPL_RESET;
    localparam int LC_INIT  = (LC_RESET > MAX_LINES) ? MAX_LINES : LC_RESET;

    logic [15:0] cell_store_reg [DEPTH];
    logic [15:0] rd_data_reg;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;

    logic [CPL_W-1:0]  cpl_reg, cpl_next;
    logic [LC_W-1:0]   lc_reg, lc_next;
    logic [3:0]        fg_reg, fg_next;
    logic [3:0]        bg_reg, bg_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              pend_reg, pend_next;
    logic              down_reg, down_next;
    logic [ADDR_W-1:0] fill_base_reg, fill_base_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic [LC_CFG_W-1:0] lc_raw;
    logic                col_ok;
    logic                ln_ok;
    logic                on_screen;
    logic [PW-1:0]       line_prod;
    logic [ADDR_W-1:0]   line_base;
    logic [ADDR_W-1:0]   cell_addr;
    logic [SPW-1:0]      span_prod;
    logic [SPW-1:0]      screen_prod;
    logic [ADDR_W-1:0]   span_addr;
    logic                span_zero;
    logic [CNT_W-1:0]    cpl_cnt;
    logic [EW-1:0]       col_ext;
    logic [EW-1:0]       rend_clip;
    logic                range_nonempty;
    logic [15:0]         blank;
    sgr_t                sgr;

    // config registers
    assign cfg_ready = 1'b1;
    assign lc_raw    = cfg_data[LC_CFG_W-1:0];

    always_comb
    begin
        cpl_next = cpl_reg;
        lc_next  = lc_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CELLS_PER_LINE:
                begin
                    if (cfg_data == '0)
                        cpl_next = CPL_W'(1);
                    else if (int'(cfg_data) > MAX_LINE_CELLS)
                        cpl_next = CPL_W'(MAX_LINE_CELLS);
                    else
                        cpl_next = CPL_W'(cfg_data);
                end
                CFG_LINE_COUNT:
                begin
                    if (lc_raw == '0)
                        lc_next = LC_W'(1);
                    else if (int'(lc_raw) > MAX_LINES)
                        lc_next = LC_W'(MAX_LINES);
                    else
                        lc_next = LC_W'(lc_raw);
                end
                default:
                begin
                    cpl_next = cpl_reg;
                end
            endcase
        end
    end

    // command decode
    always_comb
    begin
        col_ok         = int'(cmd_reg.column) < int'(cpl_reg);
        ln_ok          = int'(cmd_reg.line) < int'(lc_reg);
        on_screen      = col_ok && ln_ok;
        line_prod      = PW'(cmd_reg.line) * PW'(cpl_reg);
        line_base      = ADDR_W'(line_prod);
        cell_addr      = line_base + ADDR_W'(cmd_reg.column);
        span_prod      = SPW'(cpl_reg) * SPW'(lc_reg - LC_W'(1));
        screen_prod    = SPW'(cpl_reg) * SPW'(lc_reg);
        span_addr      = ADDR_W'(span_prod);
        span_zero      = (span_prod == '0);
        cpl_cnt        = CNT_W'(cpl_reg);
        col_ext        = EW'(cmd_reg.column);
        rend_clip      = (EW'(cmd_reg.range_end) < EW'(cpl_reg)) ?
                         EW'(cmd_reg.range_end) : EW'(cpl_reg);
        range_nonempty = col_ext < rend_clip;
        blank          = {bg_reg, fg_reg, BLANK_CHAR};
        sgr            = sgr_decode(cmd_reg.sgr_code);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (int'(dst_reg) == DEPTH - 1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                unique case (cmd_reg.mode) inside
                    MODE_SCROLL_UP, MODE_SCROLL_DOWN:
                        state_next = span_zero ? ST_FILL : ST_COPY;
                    MODE_CLEAR_RANGE:
                        state_next = (on_screen && range_nonempty) ? ST_FILL : ST_IDLE;
                    MODE_CLEAR_LINE:
                        state_next = ln_ok ? ST_FILL : ST_IDLE;
                    MODE_CLEAR_SCREEN:
                        state_next = ST_FILL;
                    MODE_READ:
                        state_next = on_screen ? ST_READ : ST_IDLE;
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_COPY:
            begin
                if (rem_reg == '0 && !pend_reg)
                    state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (rem_reg == CNT_W'(1))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        src_next       = src_reg;
        dst_next       = dst_reg;
        rem_next       = rem_reg;
        pend_next      = 1'b0;
        down_next      = down_reg;
        fill_base_next = fill_base_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        done_next      = 1'b0;
        result_next    = '{cell_data: 16'd0, rejected: 1'b0};
        mem_we         = 1'b0;
        mem_waddr      = dst_reg;
        mem_wdata      = blank;
        mem_raddr      = src_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = 16'd0;
                dst_next  = dst_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                dst_next = dst_reg;
            end
            ST_EXEC:
            begin
                unique case (cmd_reg.mode) inside
                    MODE_PUT, MODE_CLEAR_CELL:
                    begin
                        done_next            = 1'b1;
                        result_next.rejected = !on_screen;
                        mem_we               = on_screen;
                        mem_waddr            = cell_addr;
                        mem_wdata            = (cmd_reg.mode == MODE_PUT) ?
                                               {bg_reg, fg_reg, cmd_reg.char_code} : blank;
                    end
                    MODE_SCROLL_UP:
                    begin
                        src_next       = ADDR_W'(cpl_reg);
                        dst_next       = span_zero ? span_addr : '0;
                        rem_next       = span_zero ? cpl_cnt : CNT_W'(span_prod);
                        down_next      = 1'b0;
                        fill_base_next = span_addr;
                    end
                    MODE_SCROLL_DOWN:
                    begin
                        src_next       = span_addr - ADDR_W'(1);
                        dst_next       = span_zero ? '0 :
                                         span_addr + ADDR_W'(cpl_reg) - ADDR_W'(1);
                        rem_next       = span_zero ? cpl_cnt : CNT_W'(span_prod);
                        down_next      = 1'b1;
                        fill_base_next = '0;
                    end
                    MODE_CLEAR_RANGE:
                    begin
                        dst_next = cell_addr;
                        rem_next = CNT_W'(rend_clip - col_ext);
                        if (!on_screen || !range_nonempty)
                        begin
                            done_next            = 1'b1;
                            result_next.rejected = !on_screen;
                        end
                    end
                    MODE_CLEAR_LINE:
                    begin
                        dst_next = line_base;
                        rem_next = cpl_cnt;
                        if (!ln_ok)
                        begin
                            done_next            = 1'b1;
                            result_next.rejected = 1'b1;
                        end
                    end
                    MODE_CLEAR_SCREEN:
                    begin
                        dst_next = '0;
                        rem_next = CNT_W'(screen_prod);
                    end
                    MODE_SET_COLOUR:
                    begin
                        done_next            = 1'b1;
                        result_next.rejected = !sgr.hit;
                        if (sgr.hit && sgr.bg)
                            bg_next = sgr.color;
                        if (sgr.hit && !sgr.bg)
                            fg_next = sgr.color;
                    end
                    MODE_READ:
                    begin
                        mem_raddr = cell_addr;
                        if (!on_screen)
                        begin
                            done_next            = 1'b1;
                            result_next.rejected = 1'b1;
                        end
                    end
                    default:
                    begin
                        done_next            = 1'b1;
                        result_next.rejected = 1'b1;
                    end
                endcase
            end
            ST_READ:
            begin
                done_next             = 1'b1;
                result_next.cell_data = rd_data_reg;
            end
            ST_COPY:
            begin
                if (rem_reg != '0)
                begin
                    src_next  = down_reg ? src_reg - ADDR_W'(1) : src_reg + ADDR_W'(1);
                    rem_next  = rem_reg - CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data_reg;
                    dst_next  = down_reg ? dst_reg - ADDR_W'(1) : dst_reg + ADDR_W'(1);
                end
                if (rem_reg == '0 && !pend_reg)
                begin
                    dst_next = fill_base_reg;
                    rem_next = cpl_cnt;
                end
            end
            ST_FILL:
            begin
                mem_we   = 1'b1;
                dst_next = dst_reg + ADDR_W'(1);
                rem_next = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                    done_next = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cpl_reg   <= CPL_W'(CPL_INIT);
            lc_reg    <= LC_W'(LC_INIT);
            fg_reg    <= FG_RESET;
            bg_reg    <= BG_RESET;
            dst_reg   <= '0;
            rem_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cpl_reg   <= cpl_next;
            lc_reg    <= lc_next;
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            dst_reg   <= dst_next;
            rem_reg   <= rem_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            cmd_reg <= cmd;
        src_reg       <= src_next;
        down_reg      <= down_next;
        fill_base_reg <= fill_base_next;
        result_reg    <= result_next;
    end

    // cell memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_store_reg[mem_waddr] <= mem_wdata;
        rd_data_reg <= cell_store_reg[mem_raddr];
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

[dv/tb_text_cell_buffer_engine_core.sv]
// testbench for text_cell_buffer_engine_core: directed and random commands checked
// against a cycle-free screen predictor across several line and screen sizes
// depends on tcb_pkg and text_cell_buffer_engine_core
`timescale 1ns / 100ps

module tb_text_cell_buffer_engine_core;
    import tcb_pkg::*;

    localparam logic [2:0] ANSI_TO_VGA [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
    localparam int SCREEN_CELLS = MAX_LINE_CELLS_DEF * MAX_LINES_DEF;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    cmd_t       cmd = '0;
    logic       done;
    result_t    result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_reg_t   cfg_index = CFG_CELLS_PER_LINE;
    logic [7:0] cfg_data = 8'd0;

    // screen predictor state
    logic [15:0] screen_mem [SCREEN_CELLS];
    logic [3:0]  cur_fg;
    logic [3:0]  cur_bg;
    int          row_cells;
    int          row_total;

    cmd_t    pending_cmds [$];
    result_t expected_results [$];
    result_t oldest;
    int      taken_count = 0;
    int      sent_count = 0;
    int      gap_left = 0;
    bit      no_gaps = 1'b0;
    int      mismatch_count = 0;

    text_cell_buffer_engine_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int clamp_reg(input int v, input int hi);
        if (v < 1)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic bit fits(input int col, input int ln);
        return col < row_cells && ln < row_total;
    endfunction

    function automatic result_t screen_update(input cmd_t c);
        result_t     r;
        int          col;
        int          ln;
        int          span;
        int          e;
        int          i;
        int          v;
        logic [15:0] blank;
        r.cell_data = '0;
        r.rejected  = 1'b0;
        col   = int'(c.column);
        ln    = int'(c.line);
        span  = row_cells * (row_total - 1);
        blank = {cur_bg, cur_fg, BLANK_CHAR};
        case (c.mode)
            MODE_PUT:
            begin
                if (fits(col, ln))
                    screen_mem[ln * row_cells + col] = {cur_bg, cur_fg, c.char_code};
                else
                    r.rejected = 1'b1;
            end
            MODE_SCROLL_UP:
            begin
                for (i = 0; i < span; i++)
                    screen_mem[i] = screen_mem[i + row_cells];
                for (i = 0; i < row_cells; i++)
                    screen_mem[span + i] = blank;
            end
            MODE_SCROLL_DOWN:
            begin
                for (i = span + row_cells; i > row_cells; i--)
                    screen_mem[i - 1] = screen_mem[i - 1 - row_cells];
                for (i = 0; i < row_cells; i++)
                    screen_mem[i] = blank;
            end
            MODE_CLEAR_CELL:
            begin
                if (fits(col, ln))
                    screen_mem[ln * row_cells + col] = blank;
                else
                    r.rejected = 1'b1;
            end
            MODE_CLEAR_RANGE:
            begin
                if (fits(col, ln))
                begin
                    e = (c.range_end < row_cells) ? int'(c.range_end) : row_cells;
                    for (i = col; i < e; i++)
                        screen_mem[ln * row_cells + i] = blank;
                end
                else
                begin
                    r.rejected = 1'b1;
                end
            end
            MODE_CLEAR_LINE:
            begin
                if (ln < row_total)
                begin
                    for (i = 0; i < row_cells; i++)
                        screen_mem[ln * row_cells + i] = blank;
                end
                else
                begin
                    r.rejected = 1'b1;
                end
            end
            MODE_CLEAR_SCREEN:
            begin
                for (i = 0; i < row_cells * row_total; i++)
                    screen_mem[i] = blank;
            end
            MODE_SET_COLOUR:
            begin
                v = int'(c.sgr_code);
                if (v >= SGR_FG_LO && v <= SGR_FG_HI)
                    cur_fg = {1'b0, ANSI_TO_VGA[v % 10]};
                else if (v >= SGR_FG_BR_LO && v <= SGR_FG_BR_HI)
                    cur_fg = {1'b1, ANSI_TO_VGA[v % 10]};
                else if (v >= SGR_BG_LO && v <= SGR_BG_HI)
                    cur_bg = {1'b0, ANSI_TO_VGA[v % 10]};
                else if (v >= SGR_BG_BR_LO && v <= SGR_BG_BR_HI)
                    cur_bg = {1'b1, ANSI_TO_VGA[v % 10]};
                else
                    r.rejected = 1'b1;
            end
            MODE_READ:
            begin
                if (fits(col, ln))
                    r.cell_data = screen_mem[ln * row_cells + col];
                else
                    r.rejected = 1'b1;
            end
            default:
            begin
                r.rejected = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic cmd_t mk_cmd(input mode_t m, input int ch, input int col, input int ln,
                                    input int rend, input int sgr);
        cmd_t c;
        c.mode      = m;
        c.char_code = 8'(ch);
        c.column    = 7'(col);
        c.line      = 5'(ln);
        c.range_end = 8'(rend);
        c.sgr_code  = 7'(sgr);
        return c;
    endfunction

    function automatic cmd_t random_cmd(input int cpl, input int lc);
        cmd_t c;
        int   pick;
        int   base;
        int   e;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            c.mode = MODE_PUT;
        else if (pick < 55)
            c.mode = MODE_READ;
        else if (pick < 63)
            c.mode = MODE_CLEAR_CELL;
        else if (pick < 71)
            c.mode = MODE_CLEAR_RANGE;
        else if (pick < 77)
            c.mode = MODE_CLEAR_LINE;
        else if (pick < 87)
            c.mode = MODE_SET_COLOUR;
        else if (pick < 91)
            c.mode = MODE_SCROLL_UP;
        else if (pick < 95)
            c.mode = MODE_SCROLL_DOWN;
        else if (pick < 98)
            c.mode = MODE_CLEAR_SCREEN;
        else
            c.mode = mode_t'(4'($urandom_range(9, 15)));
        c.char_code = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) != 0)
            c.column = 7'($urandom_range(0, cpl - 1));
        else
            c.column = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 9) != 0)
            c.line = 5'($urandom_range(0, lc - 1));
        else
            c.line = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 9) < 6)
        begin
            e = int'(c.column) + $urandom_range(0, 8);
            if (e > 128)
                e = 128;
        end
        else
        begin
            e = $urandom_range(0, 128);
        end
        c.range_end = 8'(e);
        if ($urandom_range(0, 3) != 0)
        begin
            case ($urandom_range(0, 3))
                0: base = SGR_FG_LO;
                1: base = SGR_FG_BR_LO;
                2: base = SGR_BG_LO;
                default: base = SGR_BG_BR_LO;
            endcase
            c.sgr_code = 7'(base + $urandom_range(0, 7));
        end
        else
        begin
            c.sgr_code = 7'($urandom_range(0, 127));
        end
        return c;
    endfunction

    // monitor: check results, then track config and command transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t unexpected result: expected none, actual %h", $time, result);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (result.cell_data !== oldest.cell_data)
                    begin
                        mismatch_count++;
                        $display("%0t cell_data mismatch: expected %h, actual %h",
                                 $time, oldest.cell_data, result.cell_data);
                    end
                    if (result.rejected !== oldest.rejected)
                    begin
                        mismatch_count++;
                        $display("%0t rejected mismatch: expected %b, actual %b",
                                 $time, oldest.rejected, result.rejected);
                    end
                end
            end
            if (cfg_valid && cfg_ready === 1'b1)
            begin
                if (cfg_index == CFG_CELLS_PER_LINE)
                    row_cells = clamp_reg(int'(cfg_data), MAX_LINE_CELLS_DEF);
                else
                    row_total = clamp_reg(int'(cfg_data & 8'h3F), MAX_LINES_DEF);
            end
            if (start && busy === 1'b0)
            begin
                expected_results.push_back(screen_update(cmd));
                taken_count++;
            end
        end
    end

    // driver: next command goes out once the current one is taken and its gap has run
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || taken_count == sent_count)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd   <= pending_cmds.pop_front();
                    start <= 1'b1;
                    sent_count++;
                    gap_left = no_gaps ? 0 : $urandom_range(0, 11);
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || taken_count != sent_count ||
               expected_results.size() != 0 || start || busy !== 1'b0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] cpl_raw, input logic [7:0] lc_raw, input int n,
                             input bit burst);
        int cpl;
        int lc;
        write_reg(CFG_CELLS_PER_LINE, cpl_raw);
        write_reg(CFG_LINE_COUNT, lc_raw);
        cpl = clamp_reg(int'(cpl_raw), MAX_LINE_CELLS_DEF);
        lc  = clamp_reg(int'(lc_raw & 8'h3F), MAX_LINES_DEF);
        no_gaps = burst;
        repeat (n) pending_cmds.push_back(random_cmd(cpl, lc));
        wait_idle();
    endtask

    initial
    begin
        for (int i = 0; i < SCREEN_CELLS; i++)
            screen_mem[i] = '0;
        cur_fg    = FG_RESET;
        cur_bg    = BG_RESET;
        row_cells = CPL_RESET;
        row_total = LC_RESET;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // reset geometry: edges, colours, clears, scrolls, unknown mode
        pending_cmds.push_back(mk_cmd(MODE_READ, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_PUT, 8'h41, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_PUT, 8'hFF, 79, 24, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_PUT, 8'h42, 80, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_PUT, 8'h43, 0, 25, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_READ, 0, 79, 24, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_READ, 0, 127, 31, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_SET_COLOUR, 0, 0, 0, 0, 31));
        pending_cmds.push_back(mk_cmd(MODE_SET_COLOUR, 0, 0, 0, 0, 97));
        pending_cmds.push_back(mk_cmd(MODE_SET_COLOUR, 0, 0, 0, 0, 44));
        pending_cmds.push_back(mk_cmd(MODE_SET_COLOUR, 0, 0, 0, 0, 107));
        pending_cmds.push_back(mk_cmd(MODE_SET_COLOUR, 0, 0, 0, 0, 38));
        pending_cmds.push_back(mk_cmd(MODE_SET_COLOUR, 0, 0, 0, 0, 127));
        pending_cmds.push_back(mk_cmd(MODE_PUT, 8'h00, 1, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_READ, 0, 1, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_CLEAR_CELL, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_CLEAR_CELL, 0, 80, 3, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_CLEAR_RANGE, 0, 2, 0, 128, 0));
        pending_cmds.push_back(mk_cmd(MODE_CLEAR_RANGE, 0, 5, 1, 3, 0));
        pending_cmds.push_back(mk_cmd(MODE_CLEAR_RANGE, 0, 80, 1, 100, 0));
        pending_cmds.push_back(mk_cmd(MODE_CLEAR_LINE, 0, 0, 24, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_CLEAR_LINE, 0, 0, 31, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_SCROLL_UP, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_SCROLL_DOWN, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_CLEAR_SCREEN, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(mode_t'(4'd12), 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(MODE_READ, 0, 79, 24, 0, 0));
        wait_idle();

        run_phase(8'd1, 8'd1, 30, 1'b0);
        run_phase(8'd128, 8'd32, 40, 1'b0);
        // zero and oversize writes clamp
        run_phase(8'd0, 8'd255, 25, 1'b1);
        run_phase(8'd255, 8'h40, 25, 1'b0);
        for (int p = 0; p < 6; p++)
            run_phase(8'($urandom_range(1, 24)), 8'($urandom_range(1, 10)), 45, p[0]);

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #(30_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
